>>> rtl/hte_pkg.sv
`default_nettype none
package hte_pkg;

  localparam int CHAR_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_BITS-1:0] CHAR_LF = CHAR_BITS'(10);
  localparam logic [CHAR_BITS-1:0] CHAR_CR = CHAR_BITS'(13);
  localparam logic [CHAR_BITS-1:0] CHAR_AMP = CHAR_BITS'(8'h26);
  localparam logic [CHAR_BITS-1:0] CHAR_LT = CHAR_BITS'(8'h3c);
  localparam logic [CHAR_BITS-1:0] CHAR_GT = CHAR_BITS'(8'h3e);

  // what the back end has to emit for one character
  typedef enum logic [2:0] {
    K_NONE,
    K_AMP,
    K_LT,
    K_GT,
    K_BR,
    K_LIT
  } kind_t;

  typedef struct packed {
    logic                 flush;  // pending cr gives <br/> first
    kind_t                kind;
    logic                 last;
    logic [CHAR_BITS-1:0] ch;
  } hte_job_t;

  function automatic logic [2:0] entity_len(kind_t kind);
    logic [2:0] len;
    case (kind)
      K_AMP:   len = 3'd5;
      K_LT:    len = 3'd4;
      K_GT:    len = 3'd4;
      K_BR:    len = 3'd5;
      K_LIT:   len = 3'd1;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] ascii_unit(kind_t kind, logic [2:0] pos);
    logic [7:0] a;
    a = 8'h00;
    case (kind)
      K_AMP: begin
        case (pos)
          3'd0:    a = "&";
          3'd1:    a = "a";
          3'd2:    a = "m";
          3'd3:    a = "p";
          default: a = ";";
        endcase
      end
      K_LT: begin
        case (pos)
          3'd0:    a = "&";
          3'd1:    a = "l";
          3'd2:    a = "t";
          default: a = ";";
        endcase
      end
      K_GT: begin
        case (pos)
          3'd0:    a = "&";
          3'd1:    a = "g";
          3'd2:    a = "t";
          default: a = ";";
        endcase
      end
      K_BR: begin
        case (pos)
          3'd0:    a = "<";
          3'd1:    a = "b";
          3'd2:    a = "r";
          3'd3:    a = "/";
          default: a = ">";
        endcase
      end
      default: a = 8'h00;
    endcase
    return a;
  endfunction

  function automatic logic [CHAR_BITS-1:0] entity_unit(kind_t kind, logic [2:0] pos,
                                                       logic [CHAR_BITS-1:0] ch);
    logic [CHAR_BITS-1:0] u;
    if (kind == K_LIT) begin
      u = ch;
    end else begin
      u = CHAR_BITS'(ascii_unit(kind, pos));
    end
    return u;
  endfunction

endpackage
`default_nettype wire

>>> rtl/html_text_escaper.sv
`default_nettype none
// html text escaper: takes text one 16-bit character per request (in_string_end
// on the last one) and emits the html-escaped text one character per request.
// '&', '<' and '>' become &amp; &lt; &gt;; with cfg_convert_newlines set, cr lf,
// a lone cr and a lone lf each become <br/>, otherwise cr and lf pass as is.
// a cr is held back until the next character (or end of string) shows whether
// an lf follows, so that input request gives no output at all.
// out_run_last marks the last output of each input request, and
// out_output_string_end the last output of the string.
// rate: one output character per clock while out_pop stays high; an input
// request expands to one character for plain text and up to ten for a held cr
// flushed ahead of an entity, all emitted by the single output sequencer. with out_pop
// high, plain text streams at one request per clock with no bubbles.
// in_full rises only when the four-entry job queue between the classifier and
// the sequencer is full; results sit in a one-entry output register.
// write cfg_convert_newlines only while no request is in flight.
module html_text_escaper (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_convert_newlines,
  // input queue side
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [hte_pkg::CHAR_BITS-1:0] in_char_code,
  input  wire logic                          in_string_end,
  // result queue side
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [hte_pkg::CHAR_BITS-1:0]      out_char,
  output logic                               out_run_last,
  output logic                               out_output_string_end
);
  import hte_pkg::*;

  hte_job_t front_job;
  hte_job_t head_job;
  logic     front_push;
  logic     q_full;
  logic     q_empty;
  logic     back_pop;
  logic     in_accept;

  // config register always takes a write
  assign cfg_ready = 1'b1;

  // input accepted whenever the job queue has room
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // front end: classify the character and track the held cr
  hte_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_convert_newlines (cfg_convert_newlines),
    .accept               (in_accept),
    .char_code            (in_char_code),
    .string_end           (in_string_end),
    .job                  (front_job),
    .job_push             (front_push)
  );

  // decoupling queue of classified jobs
  hte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_job (front_job),
    .pop      (back_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back end: walk each job's entity text into the output register
  hte_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .job                   (head_job),
    .job_valid             (!q_empty),
    .job_pop               (back_pop),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_char              (out_char),
    .out_run_last          (out_run_last),
    .out_output_string_end (out_output_string_end)
  );

endmodule
`default_nettype wire

>>> rtl/hte_front.sv
`default_nettype none
module hte_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_convert_newlines,
  input  wire logic                          accept,
  input  wire logic [hte_pkg::CHAR_BITS-1:0] char_code,
  input  wire logic                          string_end,
  output hte_pkg::hte_job_t                  job,
  output logic                               job_push
);
  import hte_pkg::*;

  logic  conv_r, conv_nxt;
  logic  cr_pending_r, cr_pending_nxt;
  kind_t kind;
  logic  hold_cr;
  logic  is_cr, is_lf;

  assign is_cr = (char_code == CHAR_CR);
  assign is_lf = (char_code == CHAR_LF);

  always_comb begin
    kind    = K_LIT;
    hold_cr = 1'b0;
    if (cr_pending_r && is_lf && conv_r) begin
      kind = K_NONE;  // cr lf pair already covered by the flush
    end else if (char_code == CHAR_AMP) begin
      kind = K_AMP;
    end else if (char_code == CHAR_LT) begin
      kind = K_LT;
    end else if (char_code == CHAR_GT) begin
      kind = K_GT;
    end else if (is_cr && conv_r) begin
      if (string_end) begin
        kind = K_BR;
      end else begin
        kind    = K_NONE;
        hold_cr = 1'b1;
      end
    end else if (is_lf && conv_r) begin
      kind = K_BR;
    end
  end

  always_comb begin
    job.flush = cr_pending_r;
    job.kind  = kind;
    job.last  = string_end;
    job.ch    = char_code;
    job_push  = accept && (cr_pending_r || (kind != K_NONE));
  end

  assign conv_nxt       = cfg_valid ? cfg_convert_newlines : conv_r;
  assign cr_pending_nxt = accept ? hold_cr : cr_pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r       <= 1'b0;
      cr_pending_r <= 1'b0;
    end else begin
      conv_r       <= conv_nxt;
      cr_pending_r <= cr_pending_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hte_queue.sv
`default_nettype none
module hte_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hte_pkg::hte_job_t push_job,
  input  wire logic              pop,
  output hte_pkg::hte_job_t      head_job,
  output logic                   full,
  output logic                   empty
);
  import hte_pkg::*;

  hte_job_t               slot_r [QUEUE_DEPTH];
  logic [QIDX_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full     = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? QIDX_BITS'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QIDX_BITS'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = QCNT_BITS'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = QCNT_BITS'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hte_back.sv
`default_nettype none
module hte_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hte_pkg::hte_job_t             job,
  input  wire logic                          job_valid,
  output logic                               job_pop,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [hte_pkg::CHAR_BITS-1:0]      out_char,
  output logic                               out_run_last,
  output logic                               out_output_string_end
);
  import hte_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0] out_char_r;
  logic                 out_run_last_r;
  logic                 out_str_end_r;
  logic [2:0]           pos_r, pos_nxt;
  logic                 flush_done_r, flush_done_nxt;
  logic                 in_flush;
  kind_t                seg_kind;
  logic [2:0]           seg_len;
  logic                 seg_end;
  logic                 job_done;
  logic                 load;

  always_comb begin
    in_flush = job.flush && !flush_done_r;
    seg_kind = in_flush ? K_BR : job.kind;
    seg_len  = entity_len(seg_kind);
    seg_end  = (pos_r == 3'(seg_len - 3'd1));
    job_done = seg_end && (!in_flush || (job.kind == K_NONE));
    load     = job_valid && (!out_valid_r || out_pop);
    job_pop  = load && job_done;
  end

  always_comb begin
    pos_nxt        = pos_r;
    flush_done_nxt = flush_done_r;
    if (load) begin
      if (job_done) begin
        pos_nxt        = 3'd0;
        flush_done_nxt = 1'b0;
      end else if (seg_end) begin
        pos_nxt        = 3'd0;
        flush_done_nxt = 1'b1;
      end else begin
        pos_nxt = 3'(pos_r + 3'd1);
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r     <= entity_unit(seg_kind, pos_r, job.ch);
      out_run_last_r <= job_done;
      out_str_end_r  <= job_done && job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pos_r        <= 3'd0;
      flush_done_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pos_r        <= pos_nxt;
      flush_done_r <= flush_done_nxt;
    end
  end

  assign out_empty             = !out_valid_r;
  assign out_char              = out_char_r;
  assign out_run_last          = out_run_last_r;
  assign out_output_string_end = out_str_end_r;

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench;
  import hte_pkg::*;

  // one expected output character of the escaper
  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic                 run_last;
    logic                 str_end;
  } esc_unit_t;

  // escape predictor plus the store of characters still to come out
  class escape_scoreboard;
    esc_unit_t expected_q[$];
    esc_unit_t run_q[$];
    bit        conv_on;
    bit        cr_held;
    int        mismatches;
    int        chars_in;
    int        chars_out;

    function void set_conv(bit v);
      conv_on = v;
    endfunction

    function void add_run(string s);
      esc_unit_t u;
      for (int i = 0; i < s.len(); i++) begin
        u.ch       = CHAR_BITS'(s[i]);
        u.run_last = 1'b0;
        u.str_end  = 1'b0;
        run_q.push_back(u);
      end
    endfunction

    function void add_literal(logic [CHAR_BITS-1:0] c);
      esc_unit_t u;
      u.ch       = c;
      u.run_last = 1'b0;
      u.str_end  = 1'b0;
      run_q.push_back(u);
    endfunction

    // works out every output character caused by one accepted input request
    function void note_input(logic [CHAR_BITS-1:0] c, bit last);
      bit paired;
      paired = 1'b0;
      run_q.delete();
      chars_in++;
      if (cr_held) begin
        cr_held = 1'b0;
        add_run("<br/>");
        paired = (c == CHAR_LF) && conv_on;
      end
      if (!paired) begin
        if (c == CHAR_AMP) begin
          add_run("&amp;");
        end else if (c == CHAR_LT) begin
          add_run("&lt;");
        end else if (c == CHAR_GT) begin
          add_run("&gt;");
        end else if (c == CHAR_CR && conv_on) begin
          if (last) begin
            add_run("<br/>");
          end else begin
            cr_held = 1'b1;
          end
        end else if (c == CHAR_LF && conv_on) begin
          add_run("<br/>");
        end else begin
          add_literal(c);
        end
      end
      if (run_q.size() > 0) begin
        run_q[$].run_last = 1'b1;
        run_q[$].str_end  = last;
      end
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [CHAR_BITS-1:0] ch, logic rl, logic se);
      esc_unit_t e;
      chars_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("output char %h with nothing expected", ch));
        return;
      end
      e = expected_q.pop_front();
      if (ch !== e.ch)
        report($sformatf("out_char %h, expected %h", ch, e.ch));
      if (rl !== e.run_last)
        report($sformatf("out_run_last %b, expected %b (char %h)", rl, e.run_last, e.ch));
      if (se !== e.str_end)
        report($sformatf("out_output_string_end %b, expected %b (char %h)", se, e.str_end,
                         e.ch));
    endtask

    task check_leftover();
      if (expected_q.size() != 0)
        report($sformatf("%0d output chars never came out", expected_q.size()));
    endtask

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_convert_newlines;
  logic                 in_push;
  logic                 in_full;
  logic [CHAR_BITS-1:0] in_char_code;
  logic                 in_string_end;
  logic                 out_empty;
  logic                 out_pop;
  logic [CHAR_BITS-1:0] out_char;
  logic                 out_run_last;
  logic                 out_output_string_end;

  escape_scoreboard sb = new();

  // sender / receiver pacing: a fast mode gives stretches with no idle cycles
  bit in_fast;
  bit out_fast;
  int cfg_writes;

  html_text_escaper dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_convert_newlines  (cfg_convert_newlines),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_char_code          (in_char_code),
    .in_string_end         (in_string_end),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_char              (out_char),
    .out_run_last          (out_run_last),
    .out_output_string_end (out_output_string_end)
  );

  always #6 clk = ~clk;

  // monitor: everything sampled at the rising edge, before the edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_conv(cfg_convert_newlines);
        cfg_writes++;
      end
      if (in_push && !in_full) sb.note_input(in_char_code, in_string_end);
      if (out_pop && !out_empty)
        sb.check_result(out_char, out_run_last, out_output_string_end);
    end
  end

  // one input request; push stays high when the next one follows with no gap
  task send_char(logic [CHAR_BITS-1:0] c, bit last);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_char_code  <= c;
    in_string_end <= last;
    do @(posedge clk); while (in_full);
  endtask

  // stop sending and wait until every expected char is out; a held-back cr
  // has no output yet and stays pending in the front end, not in the job queue
  task wait_output_drained();
    in_push <= 1'b0;
    // wait for the monitor to note the last accepted request
    @(posedge clk);
    while (sb.waiting() > 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task write_conv(bit v);
    wait_output_drained();
    cfg_convert_newlines <= v;
    cfg_valid            <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly escapable chars and newlines, the rest printable text or any 16-bit code
  function logic [CHAR_BITS-1:0] pick_char();
    logic [CHAR_BITS-1:0] c;
    case ($urandom_range(0, 9))
      0:       c = CHAR_AMP;
      1:       c = CHAR_LT;
      2:       c = CHAR_GT;
      3, 4:    c = CHAR_CR;
      5:       c = CHAR_LF;
      6, 7:    c = CHAR_BITS'($urandom_range(32, 126));
      default: c = CHAR_BITS'($urandom);
    endcase
    return c;
  endfunction

  // receiver: random pop gaps, fast stretches redrawn every so often
  initial begin
    int gap;
    int pops;
    pops    = 0;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (pops % 40 == 0) out_fast = ($urandom_range(0, 2) == 0);
      gap = out_fast ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      pops++;
    end
  end

  // stimulus
  initial begin
    bit last;
    rst_n                <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_convert_newlines <= 1'b0;
    in_push              <= 1'b0;
    in_char_code         <= '0;
    in_string_end        <= 1'b0;
    in_fast              = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // conversion off after reset: extremes and entity chars, while cr and lf pass through
    send_char('0, 1'b0);
    send_char('1, 1'b0);
    send_char(CHAR_AMP, 1'b0);
    send_char(CHAR_LT, 1'b0);
    send_char(CHAR_GT, 1'b0);
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_LF, 1'b0);
    send_char(CHAR_BITS'(8'h61), 1'b1);

    write_conv(1'b1);
    // cr lf pair gives one <br/>
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_LF, 1'b0);
    // lone cr before an ordinary char
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_BITS'(8'h78), 1'b0);
    // lone lf
    send_char(CHAR_LF, 1'b0);
    // cr after cr stays held, then flushed ahead of &amp; (longest run)
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_AMP, 1'b0);
    // cr that ends the string
    send_char(CHAR_CR, 1'b1);
    // held cr flushed by the end of the string on an entity
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_GT, 1'b1);
    // held cr survives a switch to conversion off; the lf then passes as is
    send_char(CHAR_CR, 1'b0);
    write_conv(1'b0);
    send_char(CHAR_LF, 1'b1);

    // random phases, each under its own setting; every switch waits for idle
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_conv(1'b1);
        1:       write_conv(1'b0);
        2:       write_conv(1'b1);
        default: write_conv($urandom_range(0, 1));
      endcase
      for (int i = 0; i < 52; i++) begin
        if (i % 20 == 0) in_fast = ($urandom_range(0, 2) == 0);
        // sender holds off once until the output has fully drained
        if (ph == 0 && i == 29) wait_output_drained();
        last = ($urandom_range(0, 7) == 0);
        send_char(pick_char(), last);
      end
    end

    wait_output_drained();
    sb.check_leftover();
    $display("covered %0d input chars, %0d output chars, %0d newline setting writes",
             sb.chars_in, sb.chars_out, cfg_writes);
    $display("mismatches found: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // overall limit, far above the slowest legal run
  initial begin
    #(12 * 400000);
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/hte_pkg.sv
rtl/hte_front.sv
rtl/hte_queue.sv
rtl/hte_back.sv
rtl/html_text_escaper.sv
test/testbench.sv
